[rtl/core/tgbc_pkg.sv]
// shared types and constants of the tile grid box collision block
`default_nettype none

package tgbc_pkg;

    // request kind carried on the input tuser
    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_TILE_WIDTH     = 2'd0,
        REG_TILE_HEIGHT    = 2'd1,
        REG_COLUMNS_IN_USE = 2'd2,
        REG_ROWS_IN_USE    = 2'd3
    } cfg_reg_t;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int TILE_SIZE_W = 9;
    localparam int MAP_DIM_W   = 7;
    localparam int TILE_IDX_W  = 12;
    localparam int PIXEL_W     = 16;
    localparam int COORD_W     = 6;

    localparam logic [TILE_SIZE_W-1:0] TILE_SIZE_MAX = 9'd256;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 16;

    // restoring divider runs one quotient bit per cycle
    localparam int DIV_STEPS = PIXEL_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // neighbor offsets run 0..2, standing for -1..+1
    localparam logic [1:0] SCAN_LAST = 2'd2;

endpackage

`default_nettype wire

[rtl/core/tgbc_ram.sv]
// generic single write, single read ram with registered read data
`default_nettype none

module tgbc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AddrW-1:0] wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AddrW-1:0] rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[rtl/core/tile_grid_box_collision.sv]
// top level: tile obstacle map with 3x3 neighborhood box collision query
//
// channel   dir  handshake          payload
// s_        in   tvalid / tready    tuser: opcode; tdata: tile_index, obstacle_flag, box
// m_        out  tvalid / tready    tdata: hit, hit_column, hit_row
// cfg_      in   cfg_wr_en          cfg_index, cfg_wdata (no read-back)
//
// a write request goes from S_IDLE straight to S_OUT; a query first runs two divisions
//   on the one shared restoring divider (left, then top), then steps through the neighbors:
//   skipped neighbors pass S_NB alone, in-map ones S_NB, S_READ, S_TEST (map ram read)
// after reset all MAP_COLUMNS*MAP_ROWS map ram words are swept clear, with s_tready low
// one request is in flight at a time; a finished result waits in the output register
// while the next request is already taken
`default_nettype none

module tile_grid_box_collision
    import tgbc_pkg::*;
#(
    parameter int MAP_COLUMNS = 64,
    parameter int MAP_ROWS    = 64
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [11:0] tile_index, [12] obstacle_flag, [28:13] box_left, [44:29] box_top,
    // [60:45] box_width, [76:61] box_height, [79:77] zero
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    // [0] opcode
    input  wire logic                   s_tuser,

    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [0] hit, [6:1] hit_column, [12:7] hit_row, [15:13] zero
    output logic      [M_TDATA_W-1:0]   m_tdata,

    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int MapDepth = MAP_COLUMNS * MAP_ROWS;
    localparam int AddrW    = (MapDepth > 1) ? $clog2(MapDepth) : 1;
    localparam int RdProdW  = 2 * MAP_DIM_W;
    localparam int RdExtW   = (AddrW > RdProdW) ? AddrW : RdProdW;
    localparam int WrExtW   = (AddrW > TILE_IDX_W) ? AddrW : TILE_IDX_W;
    localparam int DimCmpW  = 11;
    localparam int EdgeW    = PIXEL_W + 2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIVX,
        S_DIVY,
        S_NB,
        S_READ,
        S_TEST,
        S_OUT
    } state_t;

    // input field split
    logic [TILE_IDX_W-1:0] in_tile_index;
    logic                  in_obstacle_flag;
    logic [PIXEL_W-1:0]    in_box_left;
    logic [PIXEL_W-1:0]    in_box_top;
    logic [PIXEL_W-1:0]    in_box_width;
    logic [PIXEL_W-1:0]    in_box_height;

    assign in_tile_index    = s_tdata[11:0];
    assign in_obstacle_flag = s_tdata[12];
    assign in_box_left      = s_tdata[28:13];
    assign in_box_top       = s_tdata[44:29];
    assign in_box_width     = s_tdata[60:45];
    assign in_box_height    = s_tdata[76:61];

    // configuration registers
    logic [TILE_SIZE_W-1:0] tile_width_reg;
    logic [TILE_SIZE_W-1:0] tile_height_reg;
    logic [MAP_DIM_W-1:0]   columns_in_use_reg;
    logic [MAP_DIM_W-1:0]   rows_in_use_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tile_width_reg     <= 9'd16;
            tile_height_reg    <= 9'd16;
            columns_in_use_reg <= 7'd64;
            rows_in_use_reg    <= 7'd64;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TILE_WIDTH:     tile_width_reg     <= cfg_wdata;
                REG_TILE_HEIGHT:    tile_height_reg    <= cfg_wdata;
                REG_COLUMNS_IN_USE: columns_in_use_reg <= cfg_wdata[MAP_DIM_W-1:0];
                REG_ROWS_IN_USE:    rows_in_use_reg    <= cfg_wdata[MAP_DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped working copies of the configuration
    logic [TILE_SIZE_W-1:0] tw;
    logic [TILE_SIZE_W-1:0] th;
    logic [MAP_DIM_W-1:0]   cols;
    logic [MAP_DIM_W-1:0]   rows;

    always_comb begin
        if (tile_width_reg == '0) begin
            tw = 9'd1;
        end else if (tile_width_reg > TILE_SIZE_MAX) begin
            tw = TILE_SIZE_MAX;
        end else begin
            tw = tile_width_reg;
        end
        if (tile_height_reg == '0) begin
            th = 9'd1;
        end else if (tile_height_reg > TILE_SIZE_MAX) begin
            th = TILE_SIZE_MAX;
        end else begin
            th = tile_height_reg;
        end
        // map bound only bites when it is below the register range
        if (columns_in_use_reg == '0) begin
            cols = 7'd1;
        end else if (DimCmpW'(columns_in_use_reg) > DimCmpW'(MAP_COLUMNS)) begin
            cols = MAP_DIM_W'(MAP_COLUMNS);
        end else begin
            cols = columns_in_use_reg;
        end
        if (rows_in_use_reg == '0) begin
            rows = 7'd1;
        end else if (DimCmpW'(rows_in_use_reg) > DimCmpW'(MAP_ROWS)) begin
            rows = MAP_DIM_W'(MAP_ROWS);
        end else begin
            rows = rows_in_use_reg;
        end
    end

    // sequencer state and datapath registers
    state_t                 state_reg, state_next;
    logic [AddrW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [PIXEL_W-1:0]     box_left_reg, box_left_next;
    logic [PIXEL_W-1:0]     box_top_reg, box_top_next;
    logic [PIXEL_W-1:0]     box_width_reg, box_width_next;
    logic [PIXEL_W-1:0]     box_height_reg, box_height_next;
    logic [PIXEL_W-1:0]     div_q_reg, div_q_next;
    logic [TILE_SIZE_W-1:0] div_rem_reg, div_rem_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [PIXEL_W-1:0]     home_c_reg, home_c_next;
    logic [PIXEL_W-1:0]     home_r_reg, home_r_next;
    logic [1:0]             dr_reg, dr_next;
    logic [1:0]             dc_reg, dc_next;
    logic [MAP_DIM_W-1:0]   c_reg, c_next;
    logic [MAP_DIM_W-1:0]   r_reg, r_next;
    logic [PIXEL_W-1:0]     tl_reg, tl_next;
    logic [PIXEL_W-1:0]     tt_reg, tt_next;
    logic [AddrW-1:0]       rd_addr_reg, rd_addr_next;
    logic                   res_hit_reg, res_hit_next;
    logic [COORD_W-1:0]     res_col_reg, res_col_next;
    logic [COORD_W-1:0]     res_row_reg, res_row_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    // map ram
    logic             ram_wr_en;
    logic [AddrW-1:0] ram_wr_addr;
    logic             ram_wr_data;
    logic             ram_rd_data;

    tgbc_ram #(
        .WIDTH (1),
        .DEPTH (MapDepth)
    ) u_map_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (rd_addr_reg),
        .rd_data (ram_rd_data)
    );

    // shared divider step: one quotient bit per cycle
    logic [TILE_SIZE_W-1:0] div_divisor;
    logic [TILE_SIZE_W:0]   div_trial;
    logic [TILE_SIZE_W:0]   div_diff;
    logic                   div_ge;
    logic [TILE_SIZE_W-1:0] div_rem_step;
    logic [PIXEL_W-1:0]     div_q_step;
    logic                   div_last;

    assign div_divisor  = (state_reg == S_DIVY) ? th : tw;
    assign div_trial    = {div_rem_reg, div_q_reg[PIXEL_W-1]};
    assign div_ge       = div_trial >= {1'b0, div_divisor};
    assign div_diff     = div_trial - {1'b0, div_divisor};
    assign div_rem_step = div_ge ? div_diff[TILE_SIZE_W-1:0] : div_trial[TILE_SIZE_W-1:0];
    assign div_q_step   = {div_q_reg[PIXEL_W-2:0], div_ge};
    assign div_last     = div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1);

    // neighbor position and map bounds check
    logic [PIXEL_W:0]     nb_c_s;
    logic [PIXEL_W:0]     nb_r_s;
    logic                 nb_in_map;
    logic [MAP_DIM_W-1:0] nb_c;
    logic [MAP_DIM_W-1:0] nb_r;
    logic [RdProdW-1:0]   nb_lin;
    logic [RdExtW-1:0]    nb_lin_ext;
    logic                 scan_last;

    assign nb_c_s    = (PIXEL_W+1)'(home_c_reg) + (PIXEL_W+1)'(dc_reg) - 17'd1;
    assign nb_r_s    = (PIXEL_W+1)'(home_r_reg) + (PIXEL_W+1)'(dr_reg) - 17'd1;
    assign nb_in_map = !nb_c_s[PIXEL_W] && (nb_c_s[PIXEL_W-1:0] < PIXEL_W'(cols)) &&
                       !nb_r_s[PIXEL_W] && (nb_r_s[PIXEL_W-1:0] < PIXEL_W'(rows));
    assign nb_c      = nb_c_s[MAP_DIM_W-1:0];
    assign nb_r      = nb_r_s[MAP_DIM_W-1:0];
    assign nb_lin    = RdProdW'(nb_r) * RdProdW'(cols) + RdProdW'(nb_c);
    assign nb_lin_ext = RdExtW'(nb_lin);
    assign scan_last = (dr_reg == SCAN_LAST) && (dc_reg == SCAN_LAST);

    // strict overlap of the tile in hand with the box
    logic [EdgeW-1:0] tile_right;
    logic [EdgeW-1:0] tile_bottom;
    logic [EdgeW-1:0] box_right;
    logic [EdgeW-1:0] box_bottom;
    logic             overlap;

    assign tile_right  = EdgeW'(tl_reg) + EdgeW'(tw);
    assign tile_bottom = EdgeW'(tt_reg) + EdgeW'(th);
    assign box_right   = EdgeW'(box_left_reg) + EdgeW'(box_width_reg);
    assign box_bottom  = EdgeW'(box_top_reg) + EdgeW'(box_height_reg);
    assign overlap     = (tile_right > EdgeW'(box_left_reg)) && (EdgeW'(tl_reg) < box_right) &&
                         (tile_bottom > EdgeW'(box_top_reg)) && (EdgeW'(tt_reg) < box_bottom);

    // write request address
    logic [WrExtW-1:0] wr_idx_ext;
    logic              wr_in_map;

    assign wr_idx_ext = WrExtW'(in_tile_index);
    assign wr_in_map  = 32'(in_tile_index) < 32'(MapDepth);

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        box_left_next   = box_left_reg;
        box_top_next    = box_top_reg;
        box_width_next  = box_width_reg;
        box_height_next = box_height_reg;
        div_q_next      = div_q_reg;
        div_rem_next    = div_rem_reg;
        div_cnt_next    = div_cnt_reg;
        home_c_next     = home_c_reg;
        home_r_next     = home_r_reg;
        dr_next         = dr_reg;
        dc_next         = dc_reg;
        c_next          = c_reg;
        r_next          = r_reg;
        tl_next         = tl_reg;
        tt_next         = tt_reg;
        rd_addr_next    = rd_addr_reg;
        res_hit_next    = res_hit_reg;
        res_col_next    = res_col_reg;
        res_row_next    = res_row_reg;
        m_tdata_next    = m_tdata_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = wr_idx_ext[AddrW-1:0];
        ram_wr_data     = in_obstacle_flag;

        unique case (state_reg)
            S_CLEAR: begin
                ram_wr_en    = 1'b1;
                ram_wr_addr  = clr_cnt_reg;
                ram_wr_data  = 1'b0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AddrW'(MapDepth - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    res_hit_next = 1'b0;
                    res_col_next = '0;
                    res_row_next = '0;
                    if (opcode_t'(s_tuser) == OP_WRITE) begin
                        ram_wr_en  = wr_in_map;
                        state_next = S_OUT;
                    end else begin
                        box_left_next   = in_box_left;
                        box_top_next    = in_box_top;
                        box_width_next  = in_box_width;
                        box_height_next = in_box_height;
                        div_q_next      = in_box_left;
                        div_rem_next    = '0;
                        div_cnt_next    = '0;
                        state_next      = S_DIVX;
                    end
                end
            end
            S_DIVX: begin
                div_q_next   = div_q_step;
                div_rem_next = div_rem_step;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_last) begin
                    home_c_next  = div_q_step;
                    div_q_next   = box_top_reg;
                    div_rem_next = '0;
                    state_next   = S_DIVY;
                end
            end
            S_DIVY: begin
                div_q_next   = div_q_step;
                div_rem_next = div_rem_step;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_last) begin
                    home_r_next = div_q_step;
                    dr_next     = '0;
                    dc_next     = '0;
                    state_next  = S_NB;
                end
            end
            S_NB: begin
                if (nb_in_map) begin
                    c_next       = nb_c;
                    r_next       = nb_r;
                    rd_addr_next = nb_lin_ext[AddrW-1:0];
                    tl_next      = PIXEL_W'(nb_c) * PIXEL_W'(tw);
                    tt_next      = PIXEL_W'(nb_r) * PIXEL_W'(th);
                    state_next   = S_READ;
                end else if (scan_last) begin
                    state_next = S_OUT;
                end else if (dc_reg == SCAN_LAST) begin
                    dc_next = '0;
                    dr_next = dr_reg + 1'b1;
                end else begin
                    dc_next = dc_reg + 1'b1;
                end
            end
            S_READ: begin
                state_next = S_TEST;
            end
            S_TEST: begin
                if (ram_rd_data && overlap) begin
                    res_hit_next = 1'b1;
                    res_col_next = c_reg[COORD_W-1:0];
                    res_row_next = r_reg[COORD_W-1:0];
                    state_next   = S_OUT;
                end else if (scan_last) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_NB;
                    if (dc_reg == SCAN_LAST) begin
                        dc_next = '0;
                        dr_next = dr_reg + 1'b1;
                    end else begin
                        dc_next = dc_reg + 1'b1;
                    end
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = M_TDATA_W'({res_row_reg, res_col_reg, res_hit_reg});
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            div_cnt_reg  <= '0;
            dr_reg       <= '0;
            dc_reg       <= '0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            div_cnt_reg  <= div_cnt_next;
            dr_reg       <= dr_next;
            dc_reg       <= dc_next;
        end
        box_left_reg   <= box_left_next;
        box_top_reg    <= box_top_next;
        box_width_reg  <= box_width_next;
        box_height_reg <= box_height_next;
        div_q_reg      <= div_q_next;
        div_rem_reg    <= div_rem_next;
        home_c_reg     <= home_c_next;
        home_r_reg     <= home_r_next;
        c_reg          <= c_next;
        r_reg          <= r_next;
        tl_reg         <= tl_next;
        tt_reg         <= tt_next;
        rd_addr_reg    <= rd_addr_next;
        res_hit_reg    <= res_hit_next;
        res_col_reg    <= res_col_next;
        res_row_reg    <= res_row_next;
        m_tdata_reg    <= m_tdata_next;
    end

    // one request in flight: an accept always closes the input for the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on two consecutive cycles");

    // the map is only written by the clearing sweep or a write request
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> (state_reg == S_CLEAR) || (state_reg == S_IDLE && s_tvalid))
        else $error("map written outside clearing or a write request");

    // overlap test always sees data fetched for the tile in hand
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_TEST |-> $past(state_reg) == S_READ)
        else $error("tile test without a preceding map read");

    // a miss carries zero coordinates
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[12:1] == '0)
        else $error("miss result with nonzero coordinates");

endmodule

`default_nettype wire
